FILE: design/bitmap_set_and_find_next_top_assert.svh
// Assertion macros shared by the bitmap checker.
`ifndef BITMAP_SET_AND_FIND_NEXT_TOP_ASSERT_SVH
`define BITMAP_SET_AND_FIND_NEXT_TOP_ASSERT_SVH

// Same-cycle implication, disabled while RST is high.
`define BSFN_ASSERT_IMP(LBL, CLK, RST, ANTE, CONS, MSG) \
  LBL: assert property (@(posedge CLK) disable iff (RST) (ANTE) |-> (CONS)) else $error(MSG);

// Next-cycle implication, disabled while RST is high.
`define BSFN_ASSERT_NXT(LBL, CLK, RST, ANTE, CONS, MSG) \
  LBL: assert property (@(posedge CLK) disable iff (RST) (ANTE) |=> (CONS)) else $error(MSG);

`endif

FILE: design/bsfn_pkg.sv
// Shared constants, types and helper functions of the bitmap block.
package bsfn_pkg;

  localparam int BITS        = 1024;
  localparam int BLOCK_WIDTH = 64;
  localparam int NUM_BLOCKS  = (BITS + BLOCK_WIDTH - 1) / BLOCK_WIDTH;
  localparam int ADDR_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int BIT_W       = $clog2(BLOCK_WIDTH);
  localparam int CNT_W       = $clog2(BITS + 1);

  localparam int KIND_W  = 3;
  localparam int INDEX_W = 10;
  localparam int COUNT_W = 11;
  localparam int POS_W   = 10;

  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1024);

  typedef logic [BLOCK_WIDTH-1:0] word_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_TEST      = 3'd0,
    KIND_SET       = 3'd1,
    KIND_RESET     = 3'd2,
    KIND_START_FWD = 3'd3,
    KIND_START_REV = 3'd4,
    KIND_NEXT      = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ADDR_INDEX,
    ADDR_ZERO,
    ADDR_LAST
  } addr_sel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BIT,
    ST_START_FWD,
    ST_START_REV,
    ST_NOP,
    ST_NEXT,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic      capture;
    addr_sel_t addr_sel;
    logic      bit_op;
    logic      start_fwd;
    logic      start_rev;
    logic      step;
    logic      load;
    logic      emit;
  } dp_cmd_t;

  typedef struct packed {
    logic step_load;
  } dp_status_t;

  // Count in use, limited to the size of the map.
  function automatic logic [CNT_W-1:0] eff_count(input logic [COUNT_W-1:0] c);
    if (32'(c) > 32'(BITS)) begin
      return CNT_W'(BITS);
    end
    return CNT_W'(c);
  endfunction

  // Position of the lowest set bit; isolate it with v & -v, then encode.
  function automatic logic [BIT_W-1:0] lowest_set(input word_t v);
    word_t            iso;
    logic [BIT_W-1:0] p;
    iso = v & (~v + word_t'(1));
    p   = '0;
    for (int i = 0; i < BLOCK_WIDTH; i++) begin
      if (iso[i]) begin
        p = p | BIT_W'(i);
      end
    end
    return p;
  endfunction

  // Position of the highest set bit, through the bit-reversed word.
  function automatic logic [BIT_W-1:0] highest_set(input word_t v);
    word_t r;
    for (int i = 0; i < BLOCK_WIDTH; i++) begin
      r[i] = v[BLOCK_WIDTH-1-i];
    end
    return BIT_W'(BLOCK_WIDTH - 1) - lowest_set(r);
  endfunction

  // Mask of the bits of a block starting at start that lie below count n.
  function automatic word_t block_mask(input logic [31:0] start, input logic [31:0] n);
    word_t       m;
    logic [31:0] avail;
    avail = n - start;
    if (start >= n) begin
      m = '0;
    end else if (avail >= 32'(BLOCK_WIDTH)) begin
      m = '1;
    end else begin
      m = ~(word_t'('1) << avail[BIT_W-1:0]);
    end
    return m;
  endfunction

endpackage

FILE: design/bsfn_ctrl.sv
// Controller state machine that sequences each request through the datapath.
module bsfn_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [bsfn_pkg::KIND_W-1:0]  kind,
  input  bsfn_pkg::dp_status_t         status,
  output bsfn_pkg::dp_cmd_t            cmd,
  output logic                         busy
);
  import bsfn_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          case (kind_t'(kind))
            KIND_TEST, KIND_SET, KIND_RESET: state_next = ST_BIT;
            KIND_START_FWD:                  state_next = ST_START_FWD;
            KIND_START_REV:                  state_next = ST_START_REV;
            KIND_NEXT:                       state_next = ST_NEXT;
            default:                         state_next = ST_NOP;
          endcase
        end
      end
      ST_NEXT: begin
        state_next = status.step_load ? ST_LOAD : ST_IDLE;
      end
      ST_LOAD:  state_next = ST_NEXT;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    busy     = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        cmd.capture = start;
        case (kind_t'(kind))
          KIND_START_FWD: cmd.addr_sel = ADDR_ZERO;
          KIND_START_REV: cmd.addr_sel = ADDR_LAST;
          default:        cmd.addr_sel = ADDR_INDEX;
        endcase
      end
      ST_BIT: begin
        cmd.bit_op = 1'b1;
        cmd.emit   = 1'b1;
      end
      ST_START_FWD: begin
        cmd.start_fwd = 1'b1;
        cmd.emit      = 1'b1;
      end
      ST_START_REV: begin
        cmd.start_rev = 1'b1;
        cmd.emit      = 1'b1;
      end
      ST_NOP: begin
        cmd.emit = 1'b1;
      end
      ST_NEXT: begin
        cmd.step = 1'b1;
        cmd.emit = !status.step_load;
      end
      ST_LOAD: begin
        cmd.load = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

FILE: design/bsfn_dp.sv
// Datapath: bit store memory, count register, search cursor and result registers.
module bsfn_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  bsfn_pkg::dp_cmd_t             cmd,
  output bsfn_pkg::dp_status_t          status,
  input  logic                          cfg_we,
  input  logic [bsfn_pkg::COUNT_W-1:0]  cfg_wdata,
  input  logic [bsfn_pkg::KIND_W-1:0]   kind,
  input  logic [bsfn_pkg::INDEX_W-1:0]  bit_index,
  output logic                          bit_value,
  output logic [bsfn_pkg::POS_W-1:0]    position,
  output logic                          found,
  output logic                          index_error,
  output logic                          done
);
  import bsfn_pkg::*;

  logic [COUNT_W-1:0]   count_limit;
  logic [KIND_W-1:0]    kind_r;
  logic [INDEX_W-1:0]   idx_r;
  word_t                mem [NUM_BLOCKS];
  logic [NUM_BLOCKS-1:0] valid;
  word_t                rd_data;
  logic                 rd_vld;
  logic [ADDR_W-1:0]    rd_blk;
  logic [CNT_W-1:0]     cur_off;
  word_t                cur_block;
  logic                 cur_rev;
  logic                 cur_done;

  logic [CNT_W-1:0]     eff;
  logic [ADDR_W-1:0]    cap_addr;
  logic [ADDR_W-1:0]    step_addr;
  logic [ADDR_W-1:0]    rd_addr;
  logic                 rd_en;
  word_t                rd_word;
  word_t                rd_masked;
  logic                 err;
  logic [BIT_W-1:0]     bsel;
  logic                 old_bit;
  word_t                new_word;
  logic                 we;
  logic [CNT_W-1:0]     start_pos;
  logic [CNT_W-1:0]     n_start;
  logic [BIT_W-1:0]     hit_bit;
  logic [CNT_W-1:0]     hit_pos;
  logic                 blk_nz;
  logic                 fwd_more;
  logic                 rev_more;
  logic                 found_now;

  assign eff = eff_count(count_limit);

  always_comb begin
    case (cmd.addr_sel)
      ADDR_INDEX: cap_addr = ADDR_W'(bit_index >> BIT_W);
      ADDR_ZERO:  cap_addr = '0;
      ADDR_LAST:  cap_addr = ADDR_W'((eff - CNT_W'(1)) >> BIT_W);
      default:    cap_addr = '0;
    endcase
  end

  // Cursor step decode.
  assign start_pos = {cur_off[CNT_W-1:BIT_W], BIT_W'(0)};
  assign n_start   = start_pos + CNT_W'(BLOCK_WIDTH);
  assign blk_nz    = |cur_block;
  assign hit_bit   = cur_rev ? highest_set(cur_block) : lowest_set(cur_block);
  assign hit_pos   = {cur_off[CNT_W-1:BIT_W], hit_bit};
  assign rev_more  = (start_pos != '0);
  assign fwd_more  = (n_start < eff);
  assign found_now = !cur_done && blk_nz;
  assign step_addr = cur_rev ? ADDR_W'((start_pos - CNT_W'(1)) >> BIT_W)
                             : ADDR_W'(n_start >> BIT_W);
  assign status.step_load = !cur_done && !blk_nz && (cur_rev ? rev_more : fwd_more);

  assign rd_en   = cmd.capture || (cmd.step && status.step_load);
  assign rd_addr = cmd.capture ? cap_addr : step_addr;

  // Entries never written read as zero through the valid bits.
  assign rd_word   = rd_vld ? rd_data : '0;
  assign rd_masked = rd_word & block_mask(32'(rd_blk) << BIT_W, 32'(eff));

  // Single-bit read-modify-write.
  assign err      = (32'(idx_r) >= 32'(eff));
  assign bsel     = idx_r[BIT_W-1:0];
  assign old_bit  = rd_word[bsel];
  assign new_word = (kind_t'(kind_r) == KIND_SET) ? (rd_word | (word_t'(1) << bsel))
                                                  : (rd_word & ~(word_t'(1) << bsel));
  assign we       = cmd.bit_op && !err &&
                    ((kind_t'(kind_r) == KIND_SET) || (kind_t'(kind_r) == KIND_RESET));

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
      rd_vld  <= valid[rd_addr];
      rd_blk  <= rd_addr;
    end
    if (we) begin
      mem[rd_blk] <= new_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[rd_blk] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_limit <= COUNT_RESET;
    end else if (cfg_we) begin
      count_limit <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r <= kind;
      idx_r  <= bit_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_off   <= '0;
      cur_block <= '0;
      cur_rev   <= 1'b0;
      cur_done  <= 1'b1;
    end else if (cmd.start_fwd) begin
      cur_rev   <= 1'b0;
      cur_off   <= '0;
      cur_done  <= (eff == '0);
      cur_block <= rd_masked;
    end else if (cmd.start_rev) begin
      cur_rev   <= 1'b1;
      cur_off   <= (eff == '0) ? '0 : (eff - CNT_W'(1));
      cur_done  <= (eff == '0);
      cur_block <= rd_masked;
    end else if (cmd.load) begin
      cur_block <= rd_masked;
    end else if (cmd.step && !cur_done) begin
      if (blk_nz) begin
        cur_block <= cur_block & ~(word_t'(1) << hit_bit);
        cur_off   <= hit_pos;
      end else if (cur_rev) begin
        if (rev_more) begin
          cur_off <= start_pos - CNT_W'(1);
        end else begin
          cur_off  <= '0;
          cur_done <= 1'b1;
        end
      end else begin
        cur_off <= n_start;
        if (!fwd_more) begin
          cur_done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      bit_value   <= cmd.bit_op && !err && old_bit;
      index_error <= cmd.bit_op && err;
      found       <= cmd.step && found_now;
      position    <= (cmd.step && found_now) ? POS_W'(hit_pos) : '0;
    end
  end

endmodule

FILE: design/bitmap_set_and_find_next_top.sv
// Top level of the bitmap with set, reset, test and find-next-set-bit search.
//
//   Channel   Handshake            Payload
//   request   start / busy         kind, bit_index
//   result    done (one cycle)     bit_value, position, found, index_error
//   config    cfg_we               cfg_wdata (number of bits in use)
//
// A request is taken on a clock edge where start is high and busy is low.
// Test, set, reset, both starts and the unused kinds read the addressed block
// from the bit store, then update it, load the cursor or (test, unused kinds)
// leave it. Their result appears on the cycle after that step, with done high.
// A next request ends in its step state when the cursor's snapshot block still
// holds a set bit; else each block that the cursor moves through is read in a
// step state through the one read port of the bit store and loaded into the
// cursor in a load state, until a set bit is found or the map is exhausted.
// Reset is synchronous and leaves the map empty at once: each block has a
// valid bit, and a block never written reads as zero, so there is no clearing
// pass. The bit count returns to 1024 and the cursor is left with no search active.
// The result strobe cannot be held off; the next request may be taken on the
// cycle where the previous result is shown.
module bitmap_set_and_find_next_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [bsfn_pkg::KIND_W-1:0]   kind,
  input  logic [bsfn_pkg::INDEX_W-1:0]  bit_index,
  output logic                          done,
  output logic                          bit_value,
  output logic [bsfn_pkg::POS_W-1:0]    position,
  output logic                          found,
  output logic                          index_error,
  input  logic                          cfg_we,
  input  logic [bsfn_pkg::COUNT_W-1:0]  cfg_wdata
);
  import bsfn_pkg::*;

  // Commands from the controller and status back from the datapath.
  dp_cmd_t    cmd;
  dp_status_t status;

  // The controller only decides what happens in each cycle; all data storage,
  // including the bit store and the cursor, lives in the datapath.
  bsfn_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .kind   (kind),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // The datapath also latches the request payload on the capture command,
  // so the request ports need not hold after acceptance.
  bsfn_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .kind        (kind),
    .bit_index   (bit_index),
    .bit_value   (bit_value),
    .position    (position),
    .found       (found),
    .index_error (index_error),
    .done        (done)
  );

endmodule

FILE: design/bsfn_checker.sv
// Port-level checker for the bitmap block and its bind to the top level.
`include "bitmap_set_and_find_next_top_assert.svh"

module bsfn_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  logic                          done,
  input  logic                          bit_value,
  input  logic [bsfn_pkg::POS_W-1:0]    position,
  input  logic                          found,
  input  logic                          index_error
);

  `BSFN_ASSERT_NXT(a_reset_quiet, clk, 1'b0, rst, !busy && !done, "busy or done after reset")
  `BSFN_ASSERT_NXT(a_accept_busy, clk, rst, start && !busy, busy, "not busy after a request")
  `BSFN_ASSERT_NXT(a_strobe_single, clk, rst, done, !done, "result strobe on two cycles")
  `BSFN_ASSERT_IMP(a_flags_excl, clk, rst, done, !(found && (index_error || bit_value)), "found with bit flags")
  `BSFN_ASSERT_IMP(a_miss_pos, clk, rst, done && !found, position == '0, "position without a hit")

endmodule

bind bitmap_set_and_find_next_top bsfn_checker u_bsfn_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .bit_value   (bit_value),
  .position    (position),
  .found       (found),
  .index_error (index_error)
);
